### src/wtps_pkg.sv
package wtps_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_STEPS        = 24;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic signed [16:0] ANG_PI     = 17'sd12868;
    localparam logic signed [16:0] ANG_TWO_PI = 17'sd25736;
    localparam logic signed [28:0] Z_PI       = 29'sd52707179;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_BEGIN   = 2'd1;
    localparam logic [1:0] ACT_PREEMPT = 2'd2;

    localparam logic [1:0] PH_ALIGN    = 2'd0;
    localparam logic [1:0] PH_APPROACH = 2'd1;
    localparam logic [1:0] PH_FINAL    = 2'd2;
    localparam logic [1:0] PH_STOP     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_HEAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANG_TOL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN = 3'd5;

    localparam logic [14:0] DIST_TOL_RST  = 15'd102;
    localparam logic [13:0] ANG_TOL_RST   = 14'd71;
    localparam logic [14:0] TURN_GAIN_RST = 15'd2048;

    localparam logic [1:0] KIND_ZERO = 2'd0;
    localparam logic [1:0] KIND_GAIN = 2'd1;
    localparam logic [1:0] KIND_APPR = 2'd2;

    typedef logic signed [16:0] t_diff;
    typedef logic signed [14:0] t_ang;

    function automatic logic signed [28:0] atan_of(input logic [4:0] i);
        logic signed [28:0] v;
        case (i)
            5'd0:  v = 29'sd13176795;
            5'd1:  v = 29'sd7778716;
            5'd2:  v = 29'sd4110060;
            5'd3:  v = 29'sd2086331;
            5'd4:  v = 29'sd1047214;
            5'd5:  v = 29'sd524117;
            5'd6:  v = 29'sd262123;
            5'd7:  v = 29'sd131069;
            5'd8:  v = 29'sd65536;
            5'd9:  v = 29'sd32768;
            5'd10: v = 29'sd16384;
            5'd11: v = 29'sd8192;
            5'd12: v = 29'sd4096;
            5'd13: v = 29'sd2048;
            5'd14: v = 29'sd1024;
            5'd15: v = 29'sd512;
            5'd16: v = 29'sd256;
            5'd17: v = 29'sd128;
            5'd18: v = 29'sd64;
            5'd19: v = 29'sd32;
            5'd20: v = 29'sd16;
            5'd21: v = 29'sd8;
            5'd22: v = 29'sd4;
            5'd23: v = 29'sd2;
            default: v = 29'sd0;
        endcase
        return v;
    endfunction

endpackage

### src/wtps_if.sv
interface wtps_pose_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] pose_x;
    logic signed [15:0] pose_y;
    logic signed [14:0] pose_heading;

    modport source(output valid, action, pose_x, pose_y, pose_heading, input ready);
    modport sink(input valid, action, pose_x, pose_y, pose_heading, output ready);
endinterface

interface wtps_cmd_if;
    logic               valid;
    logic               ready;
    logic [14:0]        linear_speed;
    logic signed [15:0] angular_speed;
    logic [1:0]         phase;
    logic [15:0]        goal_range;
    logic signed [14:0] heading_error;
    logic               reached;
    logic               preempted;

    modport source(output valid, linear_speed, angular_speed, phase, goal_range,
                   heading_error, reached, preempted, input ready);
    modport sink(input valid, linear_speed, angular_speed, phase, goal_range,
                 heading_error, reached, preempted, output ready);
endinterface

### src/wtps_cordic.sv
module wtps_cordic #(
    parameter int NSTEPS = wtps_pkg::CORDIC_STEPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  wtps_pkg::t_diff i_dx,
    input  wtps_pkg::t_diff i_dy,
    output logic            o_busy,
    output wtps_pkg::t_ang  o_bearing
);
    import wtps_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_RND  = 2'd2;

    logic [1:0]         r_state;
    logic signed [43:0] r_x, r_y;
    logic signed [28:0] r_z;
    logic [4:0]         r_i;
    logic               r_zero;
    t_ang               r_bear;

    logic signed [43:0] x0, y0, xs, ys;
    logic signed [28:0] zr;

    assign x0 = {{3{i_dx[16]}}, i_dx, 24'd0};
    assign y0 = {{3{i_dy[16]}}, i_dy, 24'd0};
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign zr = (r_z + 29'sd2048) >>> 12;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    if (r_i == 5'(NSTEPS - 1)) begin
                        r_state <= C_RND;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_start) begin
            r_i    <= 5'd0;
            r_zero <= (i_dx == 17'sd0) && (i_dy == 17'sd0);
            if (i_dx < 0) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= (i_dy >= 0) ? Z_PI : -Z_PI;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= 29'sd0;
            end
        end else if (r_state == C_RUN) begin
            r_i <= r_i + 5'd1;
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_of(r_i);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_of(r_i);
            end
        end else if (r_state == C_RND) begin
            if (r_zero) begin
                r_bear <= '0;
            end else if (zr > 29'(ANG_PI)) begin
                r_bear <= 15'(ANG_PI);
            end else if (zr < -29'(ANG_PI)) begin
                r_bear <= -15'(ANG_PI);
            end else begin
                r_bear <= zr[14:0];
            end
        end
    end

    assign o_busy    = (r_state != C_IDLE);
    assign o_bearing = r_bear;

endmodule

### src/wtps_isqrt.sv
module wtps_isqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  wtps_pkg::t_diff i_dx,
    input  wtps_pkg::t_diff i_dy,
    output logic            o_busy,
    output logic [15:0]     o_root
);
    import wtps_pkg::*;

    localparam logic [1:0] Q_IDLE = 2'd0;
    localparam logic [1:0] Q_SQ   = 2'd1;
    localparam logic [1:0] Q_ADD  = 2'd2;
    localparam logic [1:0] Q_RUN  = 2'd3;

    logic [1:0]  r_state;
    t_diff       r_dx, r_dy;
    logic [32:0] r_p1, r_p2, r_n, r_r, r_bit;

    logic signed [33:0] sq1, sq2;
    logic [33:0]        sum;

    assign sq1 = r_dx * r_dx;
    assign sq2 = r_dy * r_dy;
    assign sum = {1'b0, r_r} + {1'b0, r_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
        end else begin
            unique case (r_state)
                Q_IDLE: if (i_start) r_state <= Q_SQ;
                Q_SQ:   r_state <= Q_ADD;
                Q_ADD:  r_state <= Q_RUN;
                Q_RUN:  if (r_bit[0]) r_state <= Q_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            Q_IDLE: begin
                if (i_start) begin
                    r_dx <= i_dx;
                    r_dy <= i_dy;
                end
            end
            Q_SQ: begin
                r_p1 <= sq1[32:0];
                r_p2 <= sq2[32:0];
            end
            Q_ADD: begin
                r_n   <= r_p1 + r_p2;
                r_r   <= '0;
                r_bit <= 33'h1_0000_0000;
            end
            Q_RUN: begin
                if ({1'b0, r_n} >= sum) begin
                    r_n <= r_n - sum[32:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        endcase
    end

    assign o_busy = (r_state != Q_IDLE);
    assign o_root = (r_r[32:16] != '0) ? 16'hFFFF : r_r[15:0];

endmodule

### src/waypoint_three_phase_steering_top.sv
// channel  | dir | handshake     | payload
// i_pose   | in  | valid & ready | action, pose_x, pose_y, pose_heading
// o_cmd    | out | valid & ready | speeds, phase, errors, reached, preempted
// cfg      | in  | i_cfg_we      | i_cfg_idx selects register, i_cfg_data
// one item goes through start, the square root (2 setup steps, 17 one-bit steps)
// beside the cordic pass, then evaluate, multiply and output; ready only in
// idle
// reset is synchronous, active low, and restores registers and phase at once
// a result waiting on o_cmd holds the sequencer in its last step; a new item
// is taken as soon as that result has moved into the output register
module waypoint_three_phase_steering_top #(
    parameter int CORDIC_STEPS = wtps_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    wtps_pose_if.sink                          i_pose,
    wtps_cmd_if.source                         o_cmd,
    input  logic                               i_cfg_we,
    input  logic [wtps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wtps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wtps_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic signed [15:0] r_goal_x, r_goal_y;
    t_ang               r_goal_head;
    logic [14:0]        r_dist_tol, r_gain;
    logic [13:0]        r_ang_tol;

    logic [2:0]  r_state;
    logic [1:0]  r_phase;
    logic        r_done;
    logic [1:0]  r_act;
    t_ang        r_ph;
    t_diff       r_dx, r_dy;
    t_ang        r_e, r_eh;
    logic [1:0]  r_kind;
    logic        r_reached, r_pre;
    logic [15:0] r_dist;
    logic signed [30:0] r_gp;
    logic [32:0] r_q;

    logic        r_ov;
    logic [14:0] r_lin;
    logic signed [15:0] r_ang;

    logic        c_busy, s_busy, start;
    t_ang        bear;
    logic [15:0] sq_root;

    assign start = (r_state == ST_START);

    wtps_cordic #(.NSTEPS(NSTEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_dx(r_dx), .i_dy(r_dy), .o_busy(c_busy), .o_bearing(bear)
    );

    wtps_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_dx(r_dx), .i_dy(r_dy), .o_busy(s_busy), .o_root(sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_goal_head <= '0;
            r_dist_tol  <= DIST_TOL_RST;
            r_ang_tol   <= ANG_TOL_RST;
            r_gain      <= TURN_GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GOAL_X:    r_goal_x    <= i_cfg_data;
                CFG_GOAL_Y:    r_goal_y    <= i_cfg_data;
                CFG_GOAL_HEAD: r_goal_head <= i_cfg_data[14:0];
                CFG_DIST_TOL:  r_dist_tol  <= i_cfg_data[14:0];
                CFG_ANG_TOL:   r_ang_tol   <= i_cfg_data[13:0];
                CFG_TURN_GAIN: r_gain      <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // wrapped errors and phase decision
    logic signed [16:0] db, dh;
    t_ang        e_bear, e_head;
    logic [14:0] ab, ah;
    logic        bear_ok, head_ok, dist_ok, test, rd;
    logic [1:0]  cp, n_phase, kind;
    logic        n_done, pre;
    t_ang        esel;

    always_comb begin
        db = {{2{bear[14]}}, bear} - {{2{r_ph[14]}}, r_ph};
        dh = {{2{r_goal_head[14]}}, r_goal_head} - {{2{r_ph[14]}}, r_ph};
        if (db > ANG_PI) db = db - ANG_TWO_PI;
        else if (db < -ANG_PI) db = db + ANG_TWO_PI;
        if (dh > ANG_PI) dh = dh - ANG_TWO_PI;
        else if (dh < -ANG_PI) dh = dh + ANG_TWO_PI;
        e_bear  = db[14:0];
        e_head  = dh[14:0];
        ab      = e_bear[14] ? 15'(-e_bear) : 15'(e_bear);
        ah      = e_head[14] ? 15'(-e_head) : 15'(e_head);
        bear_ok = ab < {1'b0, r_ang_tol};
        head_ok = ah < {1'b0, r_ang_tol};
        dist_ok = sq_root < {1'b0, r_dist_tol};
        test    = dist_ok && head_ok;
        rd      = (r_act == ACT_BEGIN) ? 1'b0 : r_done;
        cp      = (r_act == ACT_BEGIN) ? PH_ALIGN : r_phase;
        n_phase = cp;
        n_done  = rd;
        kind    = KIND_ZERO;
        esel    = e_bear;
        pre     = 1'b0;
        if (r_act == ACT_PREEMPT) begin
            n_phase = r_phase;
            pre     = !r_done;
            n_done  = 1'b1;
        end else if (!rd) begin
            unique case (cp)
                PH_ALIGN: begin
                    if (bear_ok) n_phase = PH_APPROACH;
                    else kind = KIND_GAIN;
                end
                PH_APPROACH: begin
                    if (dist_ok) n_phase = PH_FINAL;
                    else kind = KIND_APPR;
                end
                PH_FINAL: begin
                    esel = e_head;
                    if (head_ok) n_phase = PH_STOP;
                    else kind = KIND_GAIN;
                end
                PH_STOP: ;
            endcase
            if (test) begin
                kind   = KIND_ZERO;
                n_done = 1'b1;
            end
        end
    end

    // speed commands from the registered products
    logic signed [30:0] gs;
    logic signed [15:0] ang;
    logic [14:0]        lin;

    always_comb begin
        gs  = (r_gp + 31'sd2048) >>> 12;
        ang = '0;
        lin = '0;
        unique case (r_kind)
            KIND_GAIN: begin
                if (gs > 31'sd32767) ang = 16'sh7FFF;
                else if (gs < -31'sd32768) ang = 16'sh8000;
                else ang = gs[15:0];
            end
            KIND_APPR: begin
                ang = 16'sd410 + {r_e[14], r_e};
                lin = 15'd102 + {1'b0, r_q[32:19]};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_ALIGN;
            r_done  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == ST_FIN && (!r_ov || o_cmd.ready)) begin
                r_ov <= 1'b1;
            end else if (o_cmd.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE:  if (i_pose.valid) r_state <= ST_START;
                ST_START: r_state <= ST_WAIT;
                ST_WAIT:  if (!c_busy && !s_busy) r_state <= ST_EVAL;
                ST_EVAL: begin
                    r_phase <= n_phase;
                    r_done  <= n_done;
                    r_state <= ST_MUL;
                end
                ST_MUL:   r_state <= ST_FIN;
                ST_FIN: begin
                    if (!r_ov || o_cmd.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_pose.valid) begin
            r_act <= i_pose.action;
            r_ph  <= i_pose.pose_heading;
            r_dx  <= {r_goal_x[15], r_goal_x} - {i_pose.pose_x[15], i_pose.pose_x};
            r_dy  <= {r_goal_y[15], r_goal_y} - {i_pose.pose_y[15], i_pose.pose_y};
        end
        if (r_state == ST_EVAL) begin
            r_e       <= esel;
            r_eh      <= e_head;
            r_kind    <= kind;
            r_reached <= (r_act != ACT_PREEMPT) && test;
            r_pre     <= pre;
            r_dist    <= sq_root;
        end
        if (r_state == ST_MUL) begin
            r_gp <= $signed({16'd0, r_gain}) * $signed({{16{r_e[14]}}, r_e});
            r_q  <= 33'({1'b0, r_dist} + 17'd5) * 33'd52429;
        end
        if (r_state == ST_FIN && (!r_ov || o_cmd.ready)) begin
            r_lin <= lin;
            r_ang <= ang;
            o_cmd.phase          <= r_phase;
            o_cmd.goal_range     <= r_dist;
            o_cmd.heading_error  <= r_eh;
            o_cmd.reached        <= r_reached;
            o_cmd.preempted      <= r_pre;
        end
    end

    assign i_pose.ready        = (r_state == ST_IDLE);
    assign o_cmd.valid         = r_ov;
    assign o_cmd.linear_speed  = r_lin;
    assign o_cmd.angular_speed = r_ang;

    a_reached_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && o_cmd.reached) |->
            (o_cmd.linear_speed == '0 && o_cmd.angular_speed == '0))
        else $error("speed commanded at goal");

    a_preempt_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && o_cmd.preempted) |->
            (!o_cmd.reached && o_cmd.linear_speed == '0 && o_cmd.angular_speed == '0))
        else $error("preempted item not stopped");

    a_units_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |=> (c_busy && s_busy))
        else $error("shared units did not start");

endmodule
